>>> rtl/pse_pkg.sv
`default_nettype none

package pse_pkg;

    localparam int DATA_W          = 32;
    localparam int VALUE_W         = 31;
    localparam int OP_W            = 3;
    localparam int DEPTH_W         = 5;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int TOK_QUEUE_DEPTH = 2;

    // token opcodes on the input word; anything above OP_DIV is an unknown operator
    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

    // top of an empty stack, and what a pop of an empty stack yields
    localparam logic [DATA_W-1:0] EMPTY_TOP = '1;

    typedef enum logic [1:0] {
        KIND_PUSH    = 2'd0,
        KIND_ALU     = 2'd1,
        KIND_UNKNOWN = 2'd2
    } tok_kind_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic               start;
        tok_kind_t          kind;
        alu_op_t            alu;
        logic [VALUE_W-1:0] value;
    } tok_t;

    typedef struct packed {
        logic              start;
        logic              is_div;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } md_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } md_rsp_t;

endpackage

`default_nettype wire

>>> rtl/pse_if.sv
`default_nettype none

interface pse_in_if import pse_pkg::*;;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic               start_req;

    modport source (output valid, output op, output value, output start_req, input ready);
    modport sink   (input valid, input op, input value, input start_req, output ready);
endinterface

interface pse_out_if import pse_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       stack_depth;
    logic                     overflow;
    logic                     underflow;
    logic                     unknown_op;
    logic                     div_by_zero;

    modport source (output valid, output top_value, output stack_depth, output overflow,
                    output underflow, output unknown_op, output div_by_zero, input ready);
    modport sink   (input valid, input top_value, input stack_depth, input overflow,
                    input underflow, input unknown_op, input div_by_zero, output ready);
endinterface

`default_nettype wire

>>> rtl/pse_front.sv
`default_nettype none

module pse_front import pse_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pse_in_if.sink    tokens,
    output logic      tok_valid,
    output tok_t      tok,
    input  wire logic tok_ready
);

    localparam int QAW = (TOK_QUEUE_DEPTH > 1) ? $clog2(TOK_QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(TOK_QUEUE_DEPTH + 1);

    tok_t             q_mem [TOK_QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   fill_reg;
    tok_t             in_tok;
    logic             push;
    logic             pop;

    // decode the raw opcode
    always_comb
    begin
        in_tok.start = tokens.start_req;
        in_tok.value = tokens.value;
        in_tok.kind  = KIND_UNKNOWN;
        in_tok.alu   = ALU_ADD;
        case (tokens.op)
            OP_PUSH: in_tok.kind = KIND_PUSH;
            OP_ADD:
            begin
                in_tok.kind = KIND_ALU;
                in_tok.alu  = ALU_ADD;
            end
            OP_SUB:
            begin
                in_tok.kind = KIND_ALU;
                in_tok.alu  = ALU_SUB;
            end
            OP_MUL:
            begin
                in_tok.kind = KIND_ALU;
                in_tok.alu  = ALU_MUL;
            end
            OP_DIV:
            begin
                in_tok.kind = KIND_ALU;
                in_tok.alu  = ALU_DIV;
            end
            default: in_tok.kind = KIND_UNKNOWN;
        endcase
    end

    assign tokens.ready = (fill_reg != QCW'(TOK_QUEUE_DEPTH));
    assign tok_valid    = (fill_reg != '0);
    assign tok          = q_mem[rd_ptr_reg];
    assign push         = tokens.valid && tokens.ready;
    assign pop          = tok_valid && tok_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(TOK_QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(TOK_QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/pse_muldiv.sv
`default_nettype none

module pse_muldiv import pse_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire md_req_t req,
    output md_rsp_t      rsp
);

    localparam int SW = $clog2(DATA_W);

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_RUN  = 3'b010,
        MD_FIX  = 3'b100
    } md_state_t;

    md_state_t         state_reg;
    md_state_t         state_next;
    logic              done_reg;
    logic [SW-1:0]     step_reg;
    logic              is_div_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] acc_reg;   // product accumulator / partial remainder
    logic [DATA_W-1:0] x_reg;     // multiplicand / dividend shifting into quotient
    logic [DATA_W-1:0] y_reg;     // multiplier / divisor magnitude
    logic [DATA_W-1:0] result_reg;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;
    logic              ge;
    logic [DATA_W-1:0] mul_sum;
    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;

    assign a_mag   = req.a[DATA_W-1] ? (~req.a + 1'b1) : req.a;
    assign b_mag   = req.b[DATA_W-1] ? (~req.b + 1'b1) : req.b;
    assign rem_sh  = {acc_reg, x_reg[DATA_W-1]};
    assign diff    = rem_sh - {1'b0, y_reg};
    assign ge      = !diff[DATA_W];
    assign mul_sum = acc_reg + (y_reg[0] ? x_reg : '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            MD_IDLE: if (req.start) state_next = MD_RUN;
            MD_RUN:  if (step_reg == SW'(DATA_W - 1)) state_next = MD_FIX;
            MD_FIX:  state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == MD_FIX);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    is_div_reg <= req.is_div;
                    neg_reg    <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
                    acc_reg    <= '0;
                    step_reg   <= '0;
                    x_reg      <= req.is_div ? a_mag : req.a;
                    y_reg      <= req.is_div ? b_mag : req.b;
                end
            end
            MD_RUN:
            begin
                step_reg <= step_reg + 1'b1;
                if (is_div_reg)
                begin
                    // restoring divide, one quotient bit per cycle
                    acc_reg <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                    x_reg   <= {x_reg[DATA_W-2:0], ge};
                end
                else
                begin
                    // shift-add multiply, low word only
                    acc_reg <= mul_sum;
                    x_reg   <= {x_reg[DATA_W-2:0], 1'b0};
                    y_reg   <= {1'b0, y_reg[DATA_W-1:1]};
                end
            end
            MD_FIX:
            begin
                if (is_div_reg)
                begin
                    result_reg <= neg_reg ? (~x_reg + 1'b1) : x_reg;
                end
                else
                begin
                    result_reg <= acc_reg;
                end
            end
            default:
            begin
                step_reg <= '0;
            end
        endcase
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

`default_nettype wire

>>> rtl/pse_back.sv
`default_nettype none

module pse_back import pse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    tok_valid,
    input  wire tok_t    tok,
    output logic         tok_ready,
    output md_req_t      md_req,
    input  wire md_rsp_t md_rsp,
    pse_out_if.source    results
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_POPB   = 8'b0000_0010,
        ST_POPA   = 8'b0000_0100,
        ST_EXEC   = 8'b0000_1000,
        ST_MDWAIT = 8'b0001_0000,
        ST_PUSH   = 8'b0010_0000,
        ST_RDTOP  = 8'b0100_0000,
        ST_RESULT = 8'b1000_0000
    } bk_state_t;

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;

    bk_state_t         state_reg,  state_next;
    logic [CW-1:0]     cnt_reg,    cnt_next;
    tok_t              tok_reg,    tok_next;
    logic [DATA_W-1:0] a_reg,      a_next;
    logic [DATA_W-1:0] b_reg,      b_next;
    logic [DATA_W-1:0] res_reg,    res_next;
    logic              ovf_reg,    ovf_next;
    logic              und_reg,    und_next;
    logic              unk_reg,    unk_next;
    logic              dz_reg,     dz_next;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_top_reg;
    logic [DEPTH_W-1:0]       out_depth_reg;
    logic                     out_ovf_reg;
    logic                     out_und_reg;
    logic                     out_unk_reg;
    logic                     out_dz_reg;

    logic              load_out;
    logic              md_start;
    logic [CW-1:0]     cnt_eff;
    logic [CW-1:0]     cnt_dec;

    assign cnt_eff = tok.start ? '0 : cnt_reg;
    assign cnt_dec = (cnt_reg == '0) ? '0 : cnt_reg - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        tok_next   = tok_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        res_next   = res_reg;
        ovf_next   = ovf_reg;
        und_next   = und_reg;
        unk_next   = unk_reg;
        dz_next    = dz_reg;
        tok_ready  = 1'b0;
        wr_en      = 1'b0;
        md_start   = 1'b0;
        load_out   = 1'b0;
        rd_addr    = AW'(cnt_reg - 1'b1);

        case (state_reg)
            ST_IDLE:
            begin
                tok_ready = 1'b1;
                if (tok_valid)
                begin
                    tok_next   = tok;
                    cnt_next   = cnt_eff;
                    rd_addr    = AW'(cnt_eff - 1'b1);
                    res_next   = {1'b0, tok.value};
                    ovf_next   = 1'b0;
                    und_next   = 1'b0;
                    unk_next   = 1'b0;
                    dz_next    = 1'b0;
                    state_next = (tok.kind == KIND_PUSH) ? ST_PUSH : ST_POPB;
                end
            end
            ST_POPB:
            begin
                if (cnt_reg == '0)
                begin
                    b_next   = EMPTY_TOP;
                    und_next = 1'b1;
                end
                else
                begin
                    b_next = rd_data_reg;
                end
                cnt_next   = cnt_dec;
                rd_addr    = AW'(cnt_dec - 1'b1);
                state_next = ST_POPA;
            end
            ST_POPA:
            begin
                if (cnt_reg == '0)
                begin
                    a_next   = EMPTY_TOP;
                    und_next = 1'b1;
                end
                else
                begin
                    a_next = rd_data_reg;
                end
                cnt_next   = cnt_dec;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                case (tok_reg.kind)
                    KIND_UNKNOWN:
                    begin
                        unk_next   = 1'b1;
                        state_next = ST_RDTOP;
                    end
                    KIND_ALU:
                    begin
                        case (tok_reg.alu)
                            ALU_ADD:
                            begin
                                res_next   = a_reg + b_reg;
                                state_next = ST_PUSH;
                            end
                            ALU_SUB:
                            begin
                                res_next   = a_reg - b_reg;
                                state_next = ST_PUSH;
                            end
                            ALU_MUL:
                            begin
                                md_start   = 1'b1;
                                state_next = ST_MDWAIT;
                            end
                            ALU_DIV:
                            begin
                                if (b_reg == '0)
                                begin
                                    dz_next    = 1'b1;
                                    res_next   = '0;
                                    state_next = ST_PUSH;
                                end
                                else
                                begin
                                    md_start   = 1'b1;
                                    state_next = ST_MDWAIT;
                                end
                            end
                            default: state_next = ST_PUSH;
                        endcase
                    end
                    default: state_next = ST_PUSH;
                endcase
            end
            ST_MDWAIT:
            begin
                if (md_rsp.done)
                begin
                    res_next   = md_rsp.result;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (cnt_reg >= CW'(STACK_DEPTH))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                state_next = ST_RDTOP;
            end
            ST_RDTOP:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // stack store: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[AW'(cnt_reg)] <= res_reg;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        res_reg <= res_next;
        ovf_reg <= ovf_next;
        und_reg <= und_next;
        unk_reg <= unk_next;
        dz_reg  <= dz_next;
        if (load_out)
        begin
            out_top_reg   <= (cnt_reg == '0) ? EMPTY_TOP : rd_data_reg;
            out_depth_reg <= DEPTH_W'(cnt_reg);
            out_ovf_reg   <= ovf_reg;
            out_und_reg   <= und_reg;
            out_unk_reg   <= unk_reg;
            out_dz_reg    <= dz_reg;
        end
    end

    assign md_req.start  = md_start;
    assign md_req.is_div = (tok_reg.alu == ALU_DIV);
    assign md_req.a      = a_reg;
    assign md_req.b      = b_reg;

    assign results.valid       = out_valid_reg;
    assign results.top_value   = out_top_reg;
    assign results.stack_depth = out_depth_reg;
    assign results.overflow    = out_ovf_reg;
    assign results.underflow   = out_und_reg;
    assign results.unknown_op  = out_unk_reg;
    assign results.div_by_zero = out_dz_reg;

endmodule

`default_nettype wire

>>> rtl/postfix_stack_evaluator_top.sv
`default_nettype none

// Channel   Dir  Handshake     Word
// tokens    in   valid/ready   op[2:0], value[30:0], start_req
// results   out  valid/ready   top_value[31:0] signed, stack_depth[4:0], overflow,
//                              underflow, unknown_op, div_by_zero
//
// Back-end states per token: push IDLE, PUSH, RDTOP, RESULT; operator IDLE, POPB,
// POPA, EXEC, MDWAIT for mul/div by nonzero (32-step shift-add / restoring-divide), PUSH,
// RDTOP, RESULT; unknown op skips PUSH. One token is in the back end at a time.
// Reset (rst_n low, async) empties the stack and the token queue; stack
// contents are not cleared, read data is only used for entries below the count.
// A stalled result holds the back end in its result state; the two-entry
// token queue keeps taking input until full.

module postfix_stack_evaluator_top import pse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    pse_in_if.sink    tokens,
    pse_out_if.source results
);

    // front -> back token hand-off
    logic    tok_valid;
    logic    tok_ready;
    tok_t    tok;

    // back <-> multiply/divide unit
    md_req_t md_req;
    md_rsp_t md_rsp;

    // front: takes words, decodes the opcode, queues tokens
    pse_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tokens    (tokens),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_ready (tok_ready)
    );

    // back: stack sequencer, memory and result register
    pse_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_ready (tok_ready),
        .md_req    (md_req),
        .md_rsp    (md_rsp),
        .results   (results)
    );

    // iterative multiply / truncating divide, one bit per cycle
    pse_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

endmodule

`default_nettype wire

>>> rtl/pse_checker.sv
`default_nettype none

module pse_checker import pse_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic signed [DATA_W-1:0] top_value,
    input wire logic                     overflow,
    input wire logic                     underflow,
    input wire logic                     unknown_op,
    input wire logic                     div_by_zero
);

    // a stalled result keeps its top value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(top_value))
        else $error("result changed while stalled");

    // divide by zero always leaves a pushed zero on top
    a_dz_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero |-> top_value == '0 && !overflow)
        else $error("divide by zero did not push zero");

    // an unknown operator pushes nothing and does no arithmetic
    a_unk_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unknown_op |-> !overflow && !div_by_zero)
        else $error("unknown operator raised push or divide flag");

    // a dropped push needs a full stack, which rules out an empty pop
    a_ovf_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> !underflow)
        else $error("overflow together with underflow");

endmodule

bind postfix_stack_evaluator_top pse_checker u_pse_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .top_value   (results.top_value),
    .overflow    (results.overflow),
    .underflow   (results.underflow),
    .unknown_op  (results.unknown_op),
    .div_by_zero (results.div_by_zero)
);

`default_nettype wire
